// File: hdl/pflt_pkg.sv
package pflt_pkg;

  localparam int unsigned PEER_SLOTS_DEF = 64;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [7:0]  FAIL_LIMIT_RST = 8'd5;
  localparam logic [15:0] LOCKOUT_RST = 16'd30;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_SECONDS = 2'd1;

  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_FAILURE = 2'd1;
  localparam logic [1:0] MODE_SUCCESS = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHECK,
    OP_FAIL,
    OP_PASS
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] peer_key;
    logic [31:0] now_seconds;
    logic [31:0] deadline;
  } pflt_req_t;

endpackage

// File: hdl/peer_failure_lockout_table.sv
// Channel   Direction  Handshake             Payload
// request   in         in_valid_i/in_stall_o  mode_i, peer_key_i, now_seconds_i
// result    out        out_valid_o/out_stall_i locked_o, hit_o, evicted_o, lock_started_o
// config    in         cfg_we_i               cfg_index_i, cfg_wdata_i
//
// Each request passes through two steps in the table: it compares its key against every slot and
// then updates the slots; no new request leaves the queue until that update is done.
// A request goes from the queue into the compare registers and then into the result registers.
// Reset empties the table at once and loads a limit of 5 failures and 30 seconds of lockout.
// A two-deep queue keeps taking requests, until it is full, while a result waits on out_stall_i.
module peer_failure_lockout_table import pflt_pkg::*; #(
  parameter int unsigned PEER_SLOTS = PEER_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            mode_i,
  input  logic [63:0]           peer_key_i,
  input  logic [31:0]           now_seconds_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  locked_o,
  output logic                  hit_o,
  output logic                  evicted_o,
  output logic                  lock_started_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [7:0]  fail_limit_q;
  logic [15:0] lockout_q;
  logic        q_push, q_full, q_pop, q_empty;
  pflt_req_t   q_data, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_limit_q <= FAIL_LIMIT_RST;
      lockout_q    <= LOCKOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FAIL_LIMIT:      fail_limit_q <= cfg_wdata_i[7:0];
        REG_LOCKOUT_SECONDS: lockout_q    <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  pflt_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .peer_key_i        (peer_key_i),
    .now_seconds_i     (now_seconds_i),
    .lockout_seconds_i (lockout_q),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_data)
  );

  pflt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  pflt_back #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fail_limit_i   (fail_limit_q),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .locked_o       (locked_o),
    .hit_o          (hit_o),
    .evicted_o      (evicted_o),
    .lock_started_o (lock_started_o)
  );

endmodule

// File: hdl/pflt_front.sv
module pflt_front import pflt_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] peer_key_i,
  input  logic [31:0] now_seconds_i,
  input  logic [15:0] lockout_seconds_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output pflt_req_t   q_data_o
);

  logic [32:0] dl_sum;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // The lockout deadline saturates at the largest time value.
  assign dl_sum = {1'b0, now_seconds_i} + {17'b0, lockout_seconds_i};

  always_comb begin
    q_data_o.peer_key    = peer_key_i;
    q_data_o.now_seconds = now_seconds_i;
    q_data_o.deadline    = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    case (mode_i)
      MODE_CHECK:   q_data_o.op = OP_CHECK;
      MODE_FAILURE: q_data_o.op = OP_FAIL;
      MODE_SUCCESS: q_data_o.op = OP_PASS;
      default:      q_data_o.op = OP_NONE;
    endcase
  end

endmodule

// File: hdl/pflt_queue.sv
module pflt_queue import pflt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pflt_req_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output pflt_req_t head_o
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  pflt_req_t        mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/pflt_back.sv
module pflt_back import pflt_pkg::*; #(
  parameter int unsigned PEER_SLOTS = PEER_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] fail_limit_i,
  input  logic       q_empty_i,
  input  pflt_req_t  q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       locked_o,
  output logic       hit_o,
  output logic       evicted_o,
  output logic       lock_started_o
);

  back_state_e state_q, state_d;
  pflt_req_t   cur_q;

  logic [PEER_SLOTS-1:0] match_q, match_d, tail_mask, start_v, late_v;

  logic        valid_q [PEER_SLOTS];
  logic        valid_d [PEER_SLOTS];
  logic [63:0] key_q   [PEER_SLOTS];
  logic [63:0] key_d   [PEER_SLOTS];
  logic [7:0]  cnt_q   [PEER_SLOTS];
  logic [7:0]  cnt_d   [PEER_SLOTS];
  logic [31:0] dl_q    [PEER_SLOTS];
  logic [31:0] dl_d    [PEER_SLOTS];

  logic        up_valid [PEER_SLOTS];
  logic [63:0] up_key   [PEER_SLOTS];
  logic [7:0]  up_cnt   [PEER_SLOTS];
  logic [31:0] up_dl    [PEER_SLOTS];
  logic        dn_valid [PEER_SLOTS];
  logic [63:0] dn_key   [PEER_SLOTS];
  logic [7:0]  dn_cnt   [PEER_SLOTS];
  logic [31:0] dn_dl    [PEER_SLOTS];
  logic [8:0]  cnt_inc  [PEER_SLOTS];
  logic [7:0]  cnt_sat  [PEER_SLOTS];

  logic out_free, apply, hit, new_start;
  logic res_locked, res_hit, res_evicted, res_started;
  logic out_valid_q, locked_q, hit_q, evicted_q, started_q;

  assign hit       = |match_q;
  // With at most one matching slot, this marks that slot and every older one.
  assign tail_mask = ~(match_q - PEER_SLOTS'(1));
  assign new_start = (fail_limit_i <= 8'd1);

  for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_cell
    assign match_d[g] = valid_q[g] && (key_q[g] == q_head_i.peer_key);
    assign cnt_inc[g] = {1'b0, cnt_q[g]} + 9'd1;
    assign cnt_sat[g] = cnt_inc[g][8] ? 8'hFF : cnt_inc[g][7:0];
    assign start_v[g] = (cnt_inc[g] >= {1'b0, fail_limit_i});
    assign late_v[g]  = (dl_q[g] > cur_q.now_seconds);

    if (g == 0) begin : g_head
      assign up_valid[g] = 1'b1;
      assign up_key[g]   = cur_q.peer_key;
      assign up_cnt[g]   = new_start ? 8'd0 : 8'd1;
      assign up_dl[g]    = new_start ? cur_q.deadline : 32'd0;
    end else begin : g_body
      assign up_valid[g] = valid_q[g-1];
      assign up_key[g]   = key_q[g-1];
      assign up_cnt[g]   = cnt_q[g-1];
      assign up_dl[g]    = dl_q[g-1];
    end

    if (g == PEER_SLOTS - 1) begin : g_last
      assign dn_valid[g] = 1'b0;
      assign dn_key[g]   = key_q[g];
      assign dn_cnt[g]   = cnt_q[g];
      assign dn_dl[g]    = dl_q[g];
    end else begin : g_inner
      assign dn_valid[g] = valid_q[g+1];
      assign dn_key[g]   = key_q[g+1];
      assign dn_cnt[g]   = cnt_q[g+1];
      assign dn_dl[g]    = dl_q[g+1];
    end

    always_comb begin
      valid_d[g] = valid_q[g];
      key_d[g]   = key_q[g];
      cnt_d[g]   = cnt_q[g];
      dl_d[g]    = dl_q[g];
      if (apply) begin
        case (cur_q.op)
          OP_FAIL: begin
            if (hit) begin
              if (match_q[g]) begin
                if (start_v[g]) begin
                  cnt_d[g] = 8'd0;
                  dl_d[g]  = cur_q.deadline;
                end else begin
                  cnt_d[g] = cnt_sat[g];
                end
              end
            end else begin
              valid_d[g] = up_valid[g];
              key_d[g]   = up_key[g];
              cnt_d[g]   = up_cnt[g];
              dl_d[g]    = up_dl[g];
            end
          end
          OP_PASS: begin
            if (tail_mask[g]) begin
              valid_d[g] = dn_valid[g];
              key_d[g]   = dn_key[g];
              cnt_d[g]   = dn_cnt[g];
              dl_d[g]    = dn_dl[g];
            end
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= valid_d[g];
      end
    end

    always_ff @(posedge clk_i) begin
      key_q[g] <= key_d[g];
      cnt_q[g] <= cnt_d[g];
      dl_q[g]  <= dl_d[g];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    apply   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          apply   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_locked  = (cur_q.op == OP_CHECK) && |(match_q & late_v);
    res_hit     = (cur_q.op != OP_NONE) && hit;
    res_evicted = (cur_q.op == OP_FAIL) && !hit && valid_q[PEER_SLOTS-1];
    res_started = (cur_q.op == OP_FAIL) && (hit ? |(match_q & start_v) : new_start);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q   <= q_head_i;
      match_q <= match_d;
    end
    if (apply) begin
      locked_q  <= res_locked;
      hit_q     <= res_hit;
      evicted_q <= res_evicted;
      started_q <= res_started;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign locked_o       = locked_q;
  assign hit_o          = hit_q;
  assign evicted_o      = evicted_q;
  assign lock_started_o = started_q;

endmodule

// File: hdl/pflt_checker.sv
module pflt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic locked_o,
  input logic hit_o,
  input logic evicted_o,
  input logic lock_started_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(locked_o) && $stable(hit_o)
      && $stable(evicted_o) && $stable(lock_started_o))
    else $error("Stalled result changed.");

  a_locked_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && locked_o |-> hit_o && !evicted_o && !lock_started_o)
    else $error("Lock reported for a peer not in the table.");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o)
    else $error("Eviction reported for a peer already in the table.");

  a_start_not_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lock_started_o |-> !locked_o)
    else $error("New lockout reported together with a lock check.");

endmodule

bind peer_failure_lockout_table pflt_checker u_pflt_checker (.*);
